@@ rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the drum step sequencer: field widths,
// stream packing, command, result kind and register index codes.
// ----------------------------------------------------------------------------
package dss_pkg;

  // field widths of the input and result beats
  localparam int WIDX_W      = 9;
  localparam int NOTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 24;   // playing, write_index, write_value, zero fill
  localparam int OUT_TDATA_W = 8;    // note

  // tick count and step period widths
  localparam int TICK_W = 16;
  localparam int PER_W  = 17;        // step_ticks plus step_remainder can carry

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_BAR_TICKS  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_STEP_TICKS = 2'd1;
  localparam logic [CFG_AW-1:0] REG_STEP_REM   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_METRONOME  = 2'd3;

  // input command (travels in tuser)
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // result kinds (travel in tuser)
  localparam logic [KIND_W-1:0] KIND_PERC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BASS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLICK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAR   = 2'd3;

  // status of the remainder unit
  typedef struct packed {
    logic done;   // one-cycle pulse when the remainder is ready
    logic zero;   // remainder is zero
  } mod_res_t;

endpackage

@@ rtl/dss_mod.sv @@
// ----------------------------------------------------------------------------
// dss_mod
// Bit-serial restoring remainder unit: tick count modulo step period,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dss_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dss_pkg::TICK_W-1:0]  dividend,
  input  logic [dss_pkg::PER_W-1:0]   divisor,   // nonzero
  output dss_pkg::mod_res_t           res
);
  import dss_pkg::*;

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PER_W-1:0]  rem_r;
  logic [TICK_W-1:0] dvd_r;
  logic [PER_W-1:0]  div_r;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;

  assign trial = {rem_r, dvd_r[TICK_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(TICK_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      // keep the trial difference when it does not go negative
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[PER_W-1:0];
      end else begin
        rem_r <= trial[PER_W-1:0];
      end
      dvd_r <= {dvd_r[TICK_W-2:0], 1'b0};
    end
  end

  assign res.done = done_r;
  assign res.zero = (rem_r == '0);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a running operation");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == CNT_W'(TICK_W))
    else $error("remainder unit did not start");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && div_r != '0 && cnt_r != CNT_W'(TICK_W) |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

endmodule

@@ rtl/drum_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Steps through one bar of a drum pattern held in an on-chip pattern
// memory, giving click, percussion, bass and bar-end beats per tick.
// ----------------------------------------------------------------------------
// Tick beat: waits on the bit-serial remainder unit; a step then reads
//   DRUM_TRACKS + 1 pattern entries, and result beats follow at one per
//   cycle while the output is not stalled. A bar-end tick skips the
//   remainder unit and the reads.
// Reset (rst_n low, synchronous): registers to defaults, count and step
//   cleared; pattern memory contents stay undefined until written.
module drum_step_sequencer #(
  parameter int MAX_STEPS       = 64,
  parameter int TRACKS_PER_STEP = 5,
  parameter int DRUM_TRACKS     = 4,
  parameter int CLICK_PERIOD    = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dss_pkg::IN_TDATA_W-1:0]   in_tdata,   // playing, write_index[8:0],
                                                       // write_value[7:0], zero fill
  input  logic                             in_tuser,   // command
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dss_pkg::OUT_TDATA_W-1:0]  out_tdata,  // note[7:0]
  output logic [dss_pkg::KIND_W-1:0]       out_tuser,  // kind[1:0]
  output logic                             out_tlast,
  // configuration
  input  logic                             cfg_we,
  input  logic [dss_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [dss_pkg::CFG_DW-1:0]       cfg_wdata
);
  import dss_pkg::*;

  localparam int STORE_SIZE = MAX_STEPS * TRACKS_PER_STEP;
  localparam int NENT       = DRUM_TRACKS + 1;
  localparam int MW         = $clog2(STORE_SIZE);
  localparam int OW         = $clog2(STORE_SIZE + 1);
  localparam int SW         = OW + 5;
  localparam int MASK_W     = DRUM_TRACKS + 3;
  localparam int SEL_W      = $clog2(MASK_W);
  localparam int EIW        = $clog2(NENT);
  localparam int RCW        = $clog2(NENT + 1);
  localparam int PH_W       = $clog2(CLICK_PERIOD + 1);
  localparam int BASS_BIT   = DRUM_TRACKS + 1;
  localparam int BAR_BIT    = DRUM_TRACKS + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // configuration registers
  logic [TICK_W-1:0] bar_ticks_r;
  logic [TICK_W-1:0] step_ticks_r;
  logic [TICK_W-1:0] step_rem_r;
  logic              metro_r;

  // sequencer state
  logic [1:0]        state_r;
  logic [TICK_W-1:0] tick_cnt_r;
  logic [PH_W-1:0]   clk_ph_r;     // tick_cnt_r modulo CLICK_PERIOD
  logic [OW-1:0]     step_off_r;
  logic [MASK_W-1:0] emit_mask_r;
  logic [RCW-1:0]    rd_cnt_r;
  logic              rd_pend_r;
  logic [EIW-1:0]    rd_slot_r;
  logic              rd_inr_r;
  logic [NOTE_W-1:0] ent_r [NENT];

  // pattern memory
  logic [NOTE_W-1:0] mem [STORE_SIZE];
  logic [NOTE_W-1:0] mem_q_r;
  logic              mem_we;
  logic [MW-1:0]     mem_waddr;
  logic [MW-1:0]     mem_raddr;

  // output register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [NOTE_W-1:0] out_note_r;
  logic              out_last_r;

  // input fields
  logic              in_cmd;
  logic              in_playing;
  logic [WIDX_W-1:0] in_widx;
  logic [NOTE_W-1:0] in_wval;
  logic              in_acc;
  logic              tick_acc;
  logic              click;
  logic              at_bar_end;

  logic [PER_W-1:0]  period;
  logic [PER_W-1:0]  mod_divisor;
  logic              mod_start;
  mod_res_t          mod_res;

  logic [SW-1:0]     rd_addr;
  logic              rd_in_range;
  logic [NOTE_W-1:0] rd_value;
  logic [SW-1:0]     off_next;

  logic              out_free;
  logic [SEL_W-1:0]  sel_idx;
  logic              sel_found;
  logic [MASK_W-1:0] mask_rest;
  logic [EIW-1:0]    ent_sel;
  logic [KIND_W-1:0] sel_kind;
  logic [NOTE_W-1:0] sel_note;
  logic              emit_go;

  assign in_cmd     = in_tuser;
  assign in_playing = in_tdata[0];
  assign in_widx    = in_tdata[WIDX_W:1];
  assign in_wval    = in_tdata[WIDX_W+NOTE_W:WIDX_W+1];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign tick_acc   = in_acc && in_cmd == CMD_TICK && in_playing;
  assign click      = metro_r && clk_ph_r == '0;
  assign at_bar_end = !(tick_cnt_r < bar_ticks_r);

  // the step after the first one carries the leftover ticks
  always_comb begin
    if (step_rem_r != '0 && step_off_r == OW'(TRACKS_PER_STEP)) begin
      period = PER_W'(step_ticks_r) + PER_W'(step_rem_r);
    end else begin
      period = PER_W'(step_ticks_r);
    end
    mod_divisor = (period == '0) ? PER_W'(1) : period;
  end

  assign mod_start = tick_acc && !at_bar_end;

  dss_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (tick_cnt_r),
    .divisor  (mod_divisor),
    .res      (mod_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_ticks_r  <= TICK_W'(4000);
      step_ticks_r <= TICK_W'(250);
      step_rem_r   <= '0;
      metro_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BAR_TICKS:  bar_ticks_r  <= cfg_wdata[TICK_W-1:0];
        REG_STEP_TICKS: step_ticks_r <= cfg_wdata[TICK_W-1:0];
        REG_STEP_REM:   step_rem_r   <= cfg_wdata[TICK_W-1:0];
        REG_METRONOME:  metro_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pattern memory port
  assign mem_we      = in_acc && in_cmd == CMD_WRITE && int'(in_widx) < STORE_SIZE;
  assign mem_waddr   = MW'(in_widx);
  assign rd_addr     = SW'(step_off_r) + SW'(rd_cnt_r);
  assign rd_in_range = rd_addr < SW'(STORE_SIZE);
  assign mem_raddr   = MW'(rd_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_wval;
    end
    mem_q_r <= mem[mem_raddr];
  end

  // entries past the store read as empty
  assign rd_value = rd_inr_r ? mem_q_r : '0;
  assign off_next = SW'(step_off_r) + SW'(TRACKS_PER_STEP);

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      ent_r[rd_slot_r] <= rd_value;
    end
  end

  // pick the lowest pending result
  always_comb begin
    sel_idx   = '0;
    sel_found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (!sel_found && emit_mask_r[i]) begin
        sel_idx   = SEL_W'(i);
        sel_found = 1'b1;
      end
    end
  end

  assign mask_rest = emit_mask_r & ~(MASK_W'(1) << sel_idx);
  assign ent_sel   = EIW'(sel_idx - SEL_W'(1));

  always_comb begin
    if (sel_idx == '0) begin
      sel_kind = KIND_CLICK;
      sel_note = '0;
    end else if (sel_idx == SEL_W'(BAR_BIT)) begin
      sel_kind = KIND_BAR;
      sel_note = '0;
    end else if (sel_idx == SEL_W'(BASS_BIT)) begin
      sel_kind = KIND_BASS;
      sel_note = ent_r[ent_sel];
    end else begin
      sel_kind = KIND_PERC;
      sel_note = ent_r[ent_sel];
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign emit_go  = state_r == ST_EMIT && emit_mask_r != '0 && out_free;

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_cnt_r  <= '0;
      clk_ph_r    <= '0;
      step_off_r  <= '0;
      emit_mask_r <= '0;
      rd_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      rd_slot_r   <= '0;
      rd_inr_r    <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == ST_READ) && rd_cnt_r != RCW'(NENT);
      rd_slot_r <= EIW'(rd_cnt_r);
      rd_inr_r  <= rd_in_range;
      if (rd_pend_r) begin
        emit_mask_r[SEL_W'(rd_slot_r) + SEL_W'(1)] <= (rd_value != '0);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (tick_acc) begin
            // click in the lowest bit, bar end in the highest
            emit_mask_r <= {at_bar_end, {(MASK_W-2){1'b0}}, click};
            if (at_bar_end) begin
              tick_cnt_r <= '0;
              clk_ph_r   <= '0;
              step_off_r <= '0;
              state_r    <= ST_EMIT;
            end else begin
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_res.done) begin
            tick_cnt_r <= tick_cnt_r + TICK_W'(1);
            clk_ph_r   <= (clk_ph_r == PH_W'(CLICK_PERIOD - 1)) ? '0
                                                                : clk_ph_r + PH_W'(1);
            rd_cnt_r   <= '0;
            state_r    <= mod_res.zero ? ST_READ : ST_EMIT;
          end
        end
        ST_READ: begin
          if (rd_cnt_r == RCW'(NENT)) begin
            // advance only while a whole step still fits
            if (off_next <= SW'(STORE_SIZE)) begin
              step_off_r <= OW'(off_next);
            end
            state_r <= ST_EMIT;
          end else begin
            rd_cnt_r <= rd_cnt_r + RCW'(1);
          end
        end
        ST_EMIT: begin
          if (emit_mask_r == '0) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            emit_mask_r <= mask_rest;
            if (mask_rest == '0) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register: load a new beat whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit_go;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_kind_r <= sel_kind;
      out_note_r <= sel_note;
      out_last_r <= (mask_rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_note_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_phase_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    tick_cnt_r == '0 |-> clk_ph_r == '0)
    else $error("click phase out of step with tick count");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_off_r <= OW'(STORE_SIZE))
    else $error("step offset past pattern memory");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> emit_mask_r == '0)
    else $error("idle with results still pending");

  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == ST_READ)
    else $error("memory read data arrived outside the read window");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drum step sequencer. Pattern writes and tick
// beats go in on the input stream; a behavioral copy of the sequencer
// predicts the click, note and bar-end beats of every tick. Every result
// beat is compared against the oldest prediction. Directed tests come
// first, then random play under several register settings, with random
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int MAX_STEPS       = 64;
  localparam int TRACKS_PER_STEP = 5;
  localparam int DRUM_TRACKS     = 4;
  localparam int CLICK_PERIOD    = 1000;
  localparam int STORE_SIZE      = MAX_STEPS * TRACKS_PER_STEP;

  localparam int SETTLE_CYCLES = 48;    // longest tick with no result, with margin
  localparam int HOLD_CYCLES   = 250;
  localparam int WDOG_LIMIT    = 2000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
    logic              last;
  } seq_event_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = CMD_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr   = REG_BAR_TICKS;
  logic [CFG_DW-1:0]      cfg_wdata  = '0;

  // sequencer state as predicted
  logic [15:0]  bar_len   = 16'd4000;
  logic [15:0]  step_len  = 16'd250;
  logic [15:0]  step_rem  = 16'd0;
  logic         click_en  = 1'b0;
  logic [15:0]  tick_cnt  = 16'd0;
  int unsigned  step_base = 0;
  logic [7:0]   pattern [STORE_SIZE];
  bit           pattern_set [STORE_SIZE];

  seq_event_t   expected_events [$];
  int           err_count    = 0;
  int           quiet_cycles = 0;
  int           hold_left    = 0;
  int           stall_left   = 0;
  bit           idle_on      = 1'b1;
  logic         hold_start   = 1'b0;
  bit           hold_seen    = 1'b0;

  drum_step_sequencer #(
    .MAX_STEPS      (MAX_STEPS),
    .TRACKS_PER_STEP(TRACKS_PER_STEP),
    .DRUM_TRACKS    (DRUM_TRACKS),
    .CLICK_PERIOD   (CLICK_PERIOD)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // True when the next played tick lands on a step and reads the pattern.
  function automatic bit step_due();
    int period;
    period = step_len;
    if (step_rem > 0 && step_base == TRACKS_PER_STEP) period = step_len + step_rem;
    if (period == 0) period = 1;
    return (tick_cnt < bar_len) && (tick_cnt % period == 0);
  endfunction

  function automatic logic [7:0] rand_note();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // Advance the predicted sequencer by one accepted beat, queue its results.
  function automatic void apply_beat(logic cmd, logic play, logic [8:0] idx,
                                     logic [7:0] val);
    int          n;
    int unsigned t;
    logic [7:0]  v;
    n = 0;
    if (cmd == CMD_WRITE) begin
      if (idx < STORE_SIZE) begin
        pattern[idx]     = val;
        pattern_set[idx] = 1'b1;
      end
      return;
    end
    if (!play) return;
    if (click_en && tick_cnt % CLICK_PERIOD == 0) begin
      expected_events.push_back('{KIND_CLICK, 8'd0, 1'b0});
      n++;
    end
    if (tick_cnt < bar_len) begin
      if (step_due()) begin
        for (t = 0; t < TRACKS_PER_STEP; t++) begin
          v = (step_base + t < STORE_SIZE) ? pattern[step_base + t] : 8'd0;
          if (v != 0) begin
            expected_events.push_back('{(t == DRUM_TRACKS) ? KIND_BASS : KIND_PERC, v, 1'b0});
            n++;
          end
        end
        if (step_base + TRACKS_PER_STEP <= STORE_SIZE) step_base += TRACKS_PER_STEP;
      end
      tick_cnt++;
    end else begin
      expected_events.push_back('{KIND_BAR, 8'd0, 1'b0});
      n++;
      tick_cnt  = 16'd0;
      step_base = 0;
    end
    if (n > 0) expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  // Offer one beat, hold it until taken, then predict. Valid stays high.
  task automatic send_beat(input logic cmd, input logic play, input logic [8:0] idx,
                           input logic [7:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, idx, play};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    apply_beat(cmd, play, idx, val);
  endtask

  // Played tick; fill any unwritten entry of a step it is about to read.
  task automatic play_tick();
    int unsigned k;
    int unsigned idx;
    if (step_due()) begin
      for (k = 0; k < TRACKS_PER_STEP; k++) begin
        idx = step_base + k;
        if (idx < STORE_SIZE && !pattern_set[idx])
          send_beat(CMD_WRITE, 1'($urandom_range(0, 1)), idx[8:0], rand_note());
      end
    end
    send_beat(CMD_TICK, 1'b1, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; call only when idle.
  task automatic apply_cfg(input logic [15:0] bar, input logic [15:0] stp,
                           input logic [15:0] rem, input logic met);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BAR_TICKS;
    cfg_wdata <= bar;
    @(posedge clk);
    cfg_addr  <= REG_STEP_TICKS;
    cfg_wdata <= stp;
    @(posedge clk);
    cfg_addr  <= REG_STEP_REM;
    cfg_wdata <= rem;
    @(posedge clk);
    cfg_addr  <= REG_METRONOME;
    cfg_wdata <= {15'($urandom_range(0, 32767)), met};
    @(posedge clk);
    cfg_we    <= 1'b0;
    bar_len  = bar;
    step_len = stp;
    step_rem = rem;
    click_en = met;
  endtask

  task automatic test_store_writes();
    send_beat(CMD_WRITE, 1'b0, 9'd0, 8'd255);
    send_beat(CMD_WRITE, 1'b1, 9'd1, 8'd0);
    send_beat(CMD_WRITE, 1'b0, 9'd2, 8'd1);
    send_beat(CMD_WRITE, 1'b1, 9'd3, 8'd128);
    send_beat(CMD_WRITE, 1'b0, 9'd4, 8'd200);
    send_beat(CMD_WRITE, 1'b1, 9'd319, 8'd77);
    // out of range: dropped
    send_beat(CMD_WRITE, 1'b1, 9'd320, 8'd99);
    send_beat(CMD_WRITE, 1'b0, 9'd511, 8'd255);
    send_beat(CMD_TICK, 1'b0, 9'd511, 8'd255);
    repeat (3) play_tick();
  endtask

  task automatic test_zero_settings();
    wait_idle();
    // zero bar: every tick is a bar end, with a click at count zero
    apply_cfg(16'd0, 16'd0, 16'd0, 1'b1);
    repeat (2) play_tick();
    send_beat(CMD_WRITE, 1'b0, 9'd1, 8'd17);
    wait_idle();
    // click plus a full step of notes
    apply_cfg(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    play_tick();
    wait_idle();
    // zero period steps on every tick
    apply_cfg(16'hFFFF, 16'd0, 16'd0, 1'b0);
    repeat (3) play_tick();
  endtask

  task automatic test_step_remainder();
    wait_idle();
    apply_cfg(16'd6, 16'd2, 16'd3, 1'b0);
    repeat (10) play_tick();
  endtask

  task automatic test_store_overrun();
    int past;
    past = 0;
    wait_idle();
    apply_cfg(16'd100, 16'd1, 16'd0, 1'b0);
    while (past < 3) begin
      play_tick();
      if (step_base == STORE_SIZE) past++;
    end
  endtask

  task automatic test_metronome_bar();
    wait_idle();
    // short bar: clicks fall on the first tick after each bar end
    apply_cfg(16'd3, 16'd2, 16'd1, 1'b1);
    do play_tick(); while (tick_cnt != 0);
    repeat (6) play_tick();
  endtask

  task automatic test_backpressure();
    wait_idle();
    apply_cfg(16'd40, 16'd1, 16'd0, 1'b1);
    hold_start <= 1'b1;
    repeat (12) play_tick();
  endtask

  task automatic test_random_play();
    int phase_len [5];
    int ph;
    int n;
    int r;
    int idx;
    phase_len = '{8, 6, 8, 8, 8};
    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        1: apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        2: apply_cfg(16'($urandom_range(0, 8)), 16'd0, 16'($urandom_range(0, 2)), 1'b1);
        default: apply_cfg(16'($urandom_range(10, 120)), 16'($urandom_range(1, 6)),
                           16'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      endcase
      if (ph == 4) idle_on = 1'b0;
      n = 0;
      while (n < phase_len[ph]) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          idx = $urandom_range(0, 511);
          send_beat(CMD_WRITE, 1'($urandom_range(0, 1)), idx[8:0], rand_note());
          if (idx < STORE_SIZE) n++;
        end else if (r < 20) begin
          send_beat(CMD_TICK, 1'b0, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end else begin
          play_tick();
          n++;
        end
      end
    end
  endtask

  // Result side: check each beat, then pick the next ready level.
  always @(posedge clk) begin : result_side
    seq_event_t want;
    if (out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat: expected none, got kind %0d note %0d last %0d",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = expected_events.pop_front();
        if (out_tuser !== want.kind || out_tdata !== want.note || out_tlast !== want.last) begin
          err_count++;
          $display("%0t: mismatch: expected kind %0d note %0d last %0d, got kind %0d note %0d last %0d",
                   $time, want.kind, want.note, want.last, out_tuser, out_tdata, out_tlast);
        end
      end
    end
    if (hold_start && !hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_store_writes();
    test_zero_settings();
    test_step_remainder();
    test_store_overrun();
    test_metronome_bar();
    test_backpressure();
    test_random_play();
    wait_idle();
    if (err_count == 0 && expected_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dss_pkg.sv
rtl/dss_mod.sv
rtl/drum_step_sequencer.sv
verif/tb_top.sv
